// ===== rtl/core/ttb_pkg.sv =====
// Package for the triangle tangent/bitangent core.
// Holds field widths, the divide step count and the divider request/response types.
package ttb_pkg;
  localparam int POS_W = 32;
  localparam int TEX_W = 24;
  localparam int DP_W  = 33;
  localparam int DT_W  = 25;
  localparam int NUM_W = 60;
  localparam int DIV_STEPS = 48;  // 32 integer bits (enough to see overflow) + 16 fraction
  localparam int DEF_DIV_STEPS = DIV_STEPS;

  // Divider request and status between top and divider.
  typedef struct packed {
    logic              start;
    logic [NUM_W-1:0]  num;
    logic [NUM_W-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [31:0]       q;
    logic              clip;
  } div_rsp_t;
endpackage

// ===== rtl/core/triangle_tangent_bitangent_core.sv =====
// Triangle tangent/bitangent core: three vertex words in, one result word per triangle.
// Vertices one and two are taken without a stall; after vertex three in_stall stays high
// through the products on the shared multiplier, six divides and the output hand-off
// (no divides on a zero determinant), longer while a result word is stalled.
// One shared 33x25 multiplier and one serial divider set the rate; in_stall is high meanwhile.
// Synchronous active-low reset empties the held vertices and the result register.
module triangle_tangent_bitangent_core #(
  parameter int DIV_STEPS_P = ttb_pkg::DEF_DIV_STEPS
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [ttb_pkg::POS_W-1:0] in_pos_x,
  input  logic signed [ttb_pkg::POS_W-1:0] in_pos_y,
  input  logic signed [ttb_pkg::POS_W-1:0] in_pos_z,
  input  logic signed [ttb_pkg::TEX_W-1:0] in_tex_u,
  input  logic signed [ttb_pkg::TEX_W-1:0] in_tex_v,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [31:0] out_tangent_x,
  output logic signed [31:0] out_tangent_y,
  output logic signed [31:0] out_tangent_z,
  output logic signed [31:0] out_bitangent_x,
  output logic signed [31:0] out_bitangent_y,
  output logic signed [31:0] out_bitangent_z,
  output logic out_degenerate,
  output logic out_clipped
);
  import ttb_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;  // products through the shared multiplier
  localparam logic [2:0] S_DIV  = 3'd2;  // launch a divide
  localparam logic [2:0] S_WAIT = 3'd3;  // wait on the divider
  localparam logic [2:0] S_OUT  = 3'd4;  // hand the word to the output register

  logic [2:0] state_r, state_nxt;
  logic [1:0] phase_r;
  logic [3:0] step_r;   // multiplier step
  logic [2:0] dsel_r;   // which quotient is in flight

  // Held vertices and deltas.
  logic signed [POS_W-1:0] p1_r [3];
  logic signed [POS_W-1:0] p2_r [3];
  logic signed [TEX_W-1:0] u1_r, v1_r, u2_r, v2_r;
  logic signed [DP_W-1:0] dp1_r [3];
  logic signed [DP_W-1:0] dp2_r [3];
  logic signed [DT_W-1:0] du1_r, dv1_r, du2_r, dv2_r;

  // Shared multiplier with registered product, then accumulate.
  logic signed [DP_W-1:0] ma;
  logic signed [DT_W-1:0] mb;
  logic signed [DP_W+DT_W-1:0] prod_r;
  logic signed [NUM_W-1:0] acc_r;
  logic signed [NUM_W-1:0] det_r;
  logic signed [NUM_W-1:0] num_r [6];
  logic [31:0] res_r [6];
  logic clip_r;

  logic in_acc, out_acc;
  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign in_stall = (state_r != S_IDLE);

  // Schedule: step 2k issues first product of term k, 2k+1 the second (subtracted).
  // Terms: 0 det, 1..3 tangent xyz, 4..6 bitangent xyz. The product is registered, landing at the next step.
  logic [2:0] term;
  logic       second;
  logic [1:0] lane;     // xyz component of the current term
  assign term   = step_r[3:1];
  assign second = step_r[0];
  assign lane   = (term >= 3'd4) ? 2'(term - 3'd4) : 2'(term - 3'd1);

  always_comb begin
    ma = '0;
    mb = '0;
    case (term)
      3'd0: begin
        ma = second ? DP_W'(dv1_r) : DP_W'(du1_r);
        mb = second ? du2_r : dv2_r;
      end
      3'd1, 3'd2, 3'd3: begin
        ma = second ? dp2_r[lane] : dp1_r[lane];
        mb = second ? dv1_r : dv2_r;
      end
      3'd4, 3'd5, 3'd6: begin
        ma = second ? dp1_r[lane] : dp2_r[lane];
        mb = second ? du2_r : du1_r;
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  div_req_t dreq;
  div_rsp_t drsp;
  assign dreq.start = (state_r == S_DIV);
  assign dreq.num   = num_r[dsel_r];
  assign dreq.den   = det_r;

  ttb_div #(.STEPS(DIV_STEPS_P)) u_div (
    .clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_acc && phase_r == 2'd2) state_nxt = S_MUL;
      S_MUL:  if (step_r == 4'd14) state_nxt = (det_r == '0) ? S_OUT : S_DIV;
      S_DIV:  state_nxt = S_WAIT;
      S_WAIT: if (drsp.done) state_nxt = (dsel_r == 3'd5) ? S_OUT : S_DIV;
      S_OUT:  if (!out_valid || out_acc) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= 2'd0;
      step_r  <= '0;
      dsel_r  <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        p1_r[i] <= '0;
        p2_r[i] <= '0;
      end
      u1_r <= '0; v1_r <= '0; u2_r <= '0; v2_r <= '0;
    end else begin
      state_r <= state_nxt;
      // Load a new word when the output register is free, drop it once taken.
      if (state_r == S_OUT && (!out_valid || out_acc)) out_valid <= 1'b1;
      else if (out_acc) out_valid <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            step_r <= '0;
            dsel_r <= '0;
            clip_r <= 1'b0;
            if (phase_r == 2'd0) begin
              p1_r[0] <= in_pos_x; p1_r[1] <= in_pos_y; p1_r[2] <= in_pos_z;
              u1_r <= in_tex_u; v1_r <= in_tex_v;
              phase_r <= 2'd1;
            end else if (phase_r == 2'd1) begin
              p2_r[0] <= in_pos_x; p2_r[1] <= in_pos_y; p2_r[2] <= in_pos_z;
              u2_r <= in_tex_u; v2_r <= in_tex_v;
              phase_r <= 2'd2;
            end else begin
              // Form deltas for the third vertex.
              dp1_r[0] <= DP_W'(p2_r[0]) - DP_W'(p1_r[0]);
              dp1_r[1] <= DP_W'(p2_r[1]) - DP_W'(p1_r[1]);
              dp1_r[2] <= DP_W'(p2_r[2]) - DP_W'(p1_r[2]);
              dp2_r[0] <= DP_W'(in_pos_x) - DP_W'(p1_r[0]);
              dp2_r[1] <= DP_W'(in_pos_y) - DP_W'(p1_r[1]);
              dp2_r[2] <= DP_W'(in_pos_z) - DP_W'(p1_r[2]);
              du1_r <= DT_W'(u2_r) - DT_W'(u1_r);
              dv1_r <= DT_W'(v2_r) - DT_W'(v1_r);
              du2_r <= DT_W'(in_tex_u) - DT_W'(u1_r);
              dv2_r <= DT_W'(in_tex_v) - DT_W'(v1_r);
              phase_r <= 2'd0;
            end
          end
        end
        S_MUL: begin
          // Multiply, then accumulate the product issued at the previous step.
          step_r <= step_r + 1'b1;
          if (step_r != 4'd14) prod_r <= ma * mb;
          if (step_r != 4'd0) begin
            if (!step_r[0]) begin
              // second product of term (step-1)/2 landing: finish it
              if (step_r[3:1] == 3'd1) det_r <= acc_r - NUM_W'(prod_r);
              else num_r[step_r[3:1] - 3'd2] <= acc_r - NUM_W'(prod_r);
            end else begin
              acc_r <= NUM_W'(prod_r);
            end
          end
        end
        S_WAIT: begin
          if (drsp.done) begin
            res_r[dsel_r] <= drsp.q;
            clip_r <= clip_r | drsp.clip;
            dsel_r <= dsel_r + 1'b1;
          end
        end
        S_OUT: begin
          if (!out_valid || out_acc) begin
            out_degenerate <= (det_r == '0);
            out_clipped <= (det_r == '0) ? 1'b0 : clip_r;
            out_tangent_x   <= (det_r == '0) ? '0 : res_r[0];
            out_tangent_y   <= (det_r == '0) ? '0 : res_r[1];
            out_tangent_z   <= (det_r == '0) ? '0 : res_r[2];
            out_bitangent_x <= (det_r == '0) ? '0 : res_r[3];
            out_bitangent_y <= (det_r == '0) ? '0 : res_r[4];
            out_bitangent_z <= (det_r == '0) ? '0 : res_r[5];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Input stays stalled while the products are formed.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |-> in_stall) else $error("input taken mid-compute");
  // A divide starts only with a nonzero divisor.
  assert property (@(posedge clk) disable iff (!rst_n)
    dreq.start |-> (det_r != '0)) else $error("divide by zero launched");
  // Phase never reaches three.
  assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != 2'd3) else $error("bad vertex phase");
endmodule

// ===== rtl/core/ttb_div.sv =====
// Serial signed divider: trunc(num*2^16/den), saturated to 32 bits.
// Depends on ttb_pkg for widths and request/response structs.
module ttb_div #(
  parameter int STEPS = ttb_pkg::DEF_DIV_STEPS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ttb_pkg::div_req_t req,
  output ttb_pkg::div_rsp_t rsp
);
  import ttb_pkg::*;

  localparam int CW = $clog2(STEPS + 1);
  localparam int QW = STEPS;
  localparam int DW = NUM_W + 16;

  logic          busy_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] n_r;     // numerator magnitude scaled by 2^16, shifted out MSB first
  logic [NUM_W:0] rem_r;
  logic [NUM_W-1:0] d_r;
  logic [QW-1:0] q_r;
  logic          neg_r;
  logic          done_r;
  logic [NUM_W-1:0] nmag, dmag;
  logic [NUM_W:0] trial;
  logic [NUM_W:0] rem_sh;
  logic [QW:0]   q_abs;
  logic [31:0]   q_out;
  logic          clip_out;

  assign nmag = req.num[NUM_W-1] ? (~req.num + 1'b1) : req.num;
  assign dmag = req.den[NUM_W-1] ? (~req.den + 1'b1) : req.den;
  assign rem_sh = {rem_r[NUM_W-1:0], n_r[DW-1]};
  assign trial = rem_sh - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        // Quotient bits above STEPS are zero only if the high numerator part is small;
        // skip leading bits: numerator < 2^60, keep top DW-STEPS bits preloaded in rem.
        n_r    <= {nmag, 16'd0} << (DW - STEPS);
        rem_r  <= (NUM_W+1)'({nmag, 16'd0} >> STEPS);
        d_r    <= dmag;
        neg_r  <= req.num[NUM_W-1] ^ req.den[NUM_W-1];
        q_r    <= '0;
      end else if (busy_r) begin
        if (!trial[NUM_W]) begin
          rem_r <= trial;
          q_r   <= {q_r[QW-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          q_r   <= {q_r[QW-2:0], 1'b0};
        end
        n_r <= n_r << 1;
        if (cnt_r == CW'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // Overflow also if the preloaded high part already reaches the divisor.
  logic hi_ovf_r;
  always_ff @(posedge clk) begin
    if (req.start) hi_ovf_r <= (({nmag, 16'd0} >> STEPS) >= DW'(dmag));
  end

  always_comb begin
    q_abs = {hi_ovf_r, q_r};
    clip_out = 1'b0;
    if (neg_r) begin
      if (q_abs > (QW+1)'(33'h080000000)) begin
        clip_out = 1'b1;
        q_out = 32'h80000000;
      end else begin
        q_out = 32'(~q_abs + 1'b1);
      end
    end else if (q_abs > (QW+1)'(32'h7FFFFFFF)) begin
      clip_out = 1'b1;
      q_out = 32'h7FFFFFFF;
    end else begin
      q_out = q_abs[31:0];
    end
  end

  assign rsp.done = done_r;
  assign rsp.q    = q_out;
  assign rsp.clip = clip_out;
endmodule

// ===== dv/triangle_tangent_bitangent_core_tb.sv =====
// Testbench for the triangle tangent/bitangent core: vertex words in, one result word per
// triangle out. Depends on ttb_pkg and triangle_tangent_bitangent_core; self-checking.
module triangle_tangent_bitangent_core_tb;
  import ttb_pkg::*;

  typedef struct {
    logic signed [31:0] tx, ty, tz, bx, by, bz;
    logic               degen, clip;
  } tbn_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [POS_W-1:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic signed [TEX_W-1:0] in_tex_u = '0, in_tex_v = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_tangent_x, out_tangent_y, out_tangent_z;
  logic signed [31:0] out_bitangent_x, out_bitangent_y, out_bitangent_z;
  logic out_degenerate, out_clipped;

  // Predictor state: the held first and second vertices and the phase within the triangle.
  logic signed [31:0] held_pos [0:5];
  logic signed [23:0] held_uv [0:3];
  int unsigned        vtx_phase;

  tbn_word_t   pending_tbn[$];
  int unsigned fail_count;
  int unsigned cycle_count;
  bit          allow_idle;

  localparam int unsigned CYCLE_LIMIT = 4_000_000;

  triangle_tangent_bitangent_core i_dut (.*);

  // 12 time unit period.
  always #6 clk = ~clk;

  // Timeout watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver stalls: random bursts while idling is allowed.
  int unsigned stall_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left = stall_left - 1;
      out_stall <= 1'b1;
    end else if (allow_idle && $urandom_range(0, 3) == 0) begin
      stall_left = $urandom_range(0, 7);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Truncated Q16.16 quotient with saturation; den must be nonzero.
  function automatic logic signed [31:0] fx_quot(input logic signed [63:0] num,
                                                  input logic signed [63:0] den,
                                                  inout logic clip);
    logic [127:0] n_mag, d_mag, q;
    logic         neg;
    n_mag = num < 0 ? 128'(-num) : 128'(num);
    d_mag = den < 0 ? 128'(-den) : 128'(den);
    neg   = (num < 0) != (den < 0);
    q     = (n_mag << 16) / d_mag;
    if (neg) begin
      if (q > 128'h8000_0000) begin
        clip = 1'b1;
        q = 128'h8000_0000;
      end
      return 32'(-q);
    end
    if (q > 128'h7FFF_FFFF) begin
      clip = 1'b1;
      q = 128'h7FFF_FFFF;
    end
    return 32'(q);
  endfunction

  // Advance the predictor by one vertex; queue a result on the third.
  task automatic predict_vertex(input logic signed [31:0] px, py, pz,
                                input logic signed [23:0] u, v);
    logic signed [63:0] dp1 [3];
    logic signed [63:0] dp2 [3];
    logic signed [63:0] p3 [3];
    logic signed [63:0] du1, dv1, du2, dv2, det, tn, bn;
    logic signed [31:0] tv [3];
    logic signed [31:0] bv [3];
    logic               clip;
    tbn_word_t          w;
    if (vtx_phase < 2) begin
      held_pos[vtx_phase*3]   = px;
      held_pos[vtx_phase*3+1] = py;
      held_pos[vtx_phase*3+2] = pz;
      held_uv[vtx_phase*2]    = u;
      held_uv[vtx_phase*2+1]  = v;
      vtx_phase++;
      return;
    end
    vtx_phase = 0;
    p3[0] = px; p3[1] = py; p3[2] = pz;
    du1 = 64'(held_uv[2]) - 64'(held_uv[0]);
    dv1 = 64'(held_uv[3]) - 64'(held_uv[1]);
    du2 = 64'(u) - 64'(held_uv[0]);
    dv2 = 64'(v) - 64'(held_uv[1]);
    det = du1 * dv2 - dv1 * du2;
    clip = 1'b0;
    for (int k = 0; k < 3; k++) begin
      dp1[k] = 64'(held_pos[3+k]) - 64'(held_pos[k]);
      dp2[k] = p3[k] - 64'(held_pos[k]);
      tn = dp1[k] * dv2 - dp2[k] * dv1;
      bn = dp2[k] * du1 - dp1[k] * du2;
      tv[k] = det == 0 ? 32'sd0 : fx_quot(tn, det, clip);
      bv[k] = det == 0 ? 32'sd0 : fx_quot(bn, det, clip);
    end
    w.tx = tv[0]; w.ty = tv[1]; w.tz = tv[2];
    w.bx = bv[0]; w.by = bv[1]; w.bz = bv[2];
    w.degen = det == 0;
    w.clip  = det == 0 ? 1'b0 : clip;
    pending_tbn.push_back(w);
  endtask

  // Drive one vertex word, hold it through stalls, predict once accepted.
  // Valid stays high after the accept so the next word can follow with no gap.
  task automatic send_vertex(input logic signed [31:0] px, py, pz,
                             input logic signed [23:0] u, v);
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pos_x <= px; in_pos_y <= py; in_pos_z <= pz;
    in_tex_u <= u;  in_tex_v <= v;
    do @(posedge clk); while (in_stall);
    predict_vertex(px, py, pz, u, v);
  endtask

  function automatic logic signed [31:0] rand_pos(input int unsigned span);
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return 32'($signed($urandom_range(0, 2*span)) - $signed(span));
    endcase
  endfunction

  function automatic logic signed [23:0] rand_uv(input int unsigned span);
    case ($urandom_range(0, 5))
      0: return 24'($urandom);
      1: return $urandom_range(0, 1) ? 24'sh7F_FFFF : 24'sh80_0000;
      default: return 24'($signed($urandom_range(0, 2*span)) - $signed(span));
    endcase
  endfunction

  task automatic send_random_vertex();
    int unsigned ps, us;
    ps = $urandom_range(0, 1) ? 32'h0004_0000 : 32'h0100_0000;
    us = $urandom_range(0, 1) ? 32'h0001_0000 : 32'h0010_0000;
    send_vertex(rand_pos(ps), rand_pos(ps), rand_pos(ps), rand_uv(us), rand_uv(us));
  endtask

  // Check each accepted result word against the oldest prediction.
  always @(posedge clk) begin
    tbn_word_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_tbn.size() == 0) begin
        $display("%0t: unexpected result word tx=%h", $time, out_tangent_x);
        fail_count++;
      end else begin
        e = pending_tbn.pop_front();
        if ({out_tangent_x, out_tangent_y, out_tangent_z, out_bitangent_x, out_bitangent_y,
             out_bitangent_z, out_degenerate, out_clipped} !==
            {e.tx, e.ty, e.tz, e.bx, e.by, e.bz, e.degen, e.clip}) begin
          $display("%0t: mismatch exp t=%h %h %h b=%h %h %h d=%b c=%b", $time,
                   e.tx, e.ty, e.tz, e.bx, e.by, e.bz, e.degen, e.clip);
          $display("%0t:          act t=%h %h %h b=%h %h %h d=%b c=%b", $time,
                   out_tangent_x, out_tangent_y, out_tangent_z, out_bitangent_x,
                   out_bitangent_y, out_bitangent_z, out_degenerate, out_clipped);
          fail_count++;
        end
      end
    end
  end

  // Unit triangle: identity-like tangent frame.
  task automatic test_basic_triangle();
    send_vertex(0, 0, 0, 0, 0);
    send_vertex(32'sh1_0000, 0, 0, 24'sh1_0000, 0);
    send_vertex(0, 32'sh1_0000, 0, 0, 24'sh1_0000);
  endtask

  // Zero determinant: repeated and collinear texture coordinates.
  task automatic test_degenerate();
    send_vertex(32'sh5_0000, 3, -7, 24'sh2_0000, 24'sh2_0000);
    send_vertex(-1, 32'sh7FFF_FFFF, 9, 24'sh2_0000, 24'sh2_0000);
    send_vertex(12, -4, 32'sh8000_0000, 24'sh4_0000, 24'sh4_0000);
  endtask

  // Field extremes, one triangle with a tiny determinant: drives both saturation directions.
  task automatic test_saturation();
    send_vertex(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0);
    send_vertex(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 1, 0);
    send_vertex(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 1);
    send_vertex(0, 0, 0, 24'sh80_0000, 24'sh7F_FFFF);
    send_vertex(32'sh7FFF_FFFF, -1, 1, 24'sh7F_FFFF, 24'sh80_0000);
    send_vertex(-1, 32'sh7FFF_FFFF, 32'sh8000_0000, 24'sh7F_FFFF, 24'sh7F_FFFF);
  endtask

  // Partial triangle, then a pause until the block is drained, then complete it.
  task automatic test_held_vertices();
    send_vertex(32'sh3_0000, -32'sh2_0000, 32'sh1_8000, -24'sh1_0000, 24'sh0_8000);
    send_vertex(32'sh3_0000, 32'sh2_0000, 0, 24'sh3_0000, -24'sh1_0000);
    in_valid <= 1'b0;
    wait (pending_tbn.size() == 0);
    repeat (20) @(posedge clk);
    send_vertex(-32'sh7_0000, 5, 32'sh2_0000, 24'sh0_4000, 24'sh5_0000);
    in_valid <= 1'b0;
    wait (pending_tbn.size() == 0);
  endtask

  task automatic test_random_triangles(input int unsigned n_vertices, input bit idle);
    allow_idle = idle;
    repeat (n_vertices) send_random_vertex();
  endtask

  initial begin
    fail_count = 0;
    cycle_count = 0;
    vtx_phase = 0;
    allow_idle = 1'b1;
    for (int i = 0; i < 6; i++) held_pos[i] = '0;
    for (int i = 0; i < 4; i++) held_uv[i] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_triangle();
    test_degenerate();
    test_saturation();
    test_held_vertices();
    test_random_triangles(630, 1'b1);
    // Last stretch: no idling on either side.
    test_random_triangles(150, 1'b0);
    in_valid <= 1'b0;

    wait (pending_tbn.size() == 0);
    repeat (400) @(posedge clk);
    if (fail_count == 0 && pending_tbn.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/core/ttb_pkg.sv
rtl/core/ttb_div.sv
rtl/core/triangle_tangent_bitangent_core.sv
dv/triangle_tangent_bitangent_core_tb.sv
